[rtl/aat_pkg.sv]
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants for the affine box transform
// Register indexes, default widths and the lane control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

	// default coordinate format: signed Q16.16
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// three spatial axes, one lane per source axis
	localparam int NUM_AXES = 3;

	// configuration register index width
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

	// stage advance strobes handed to every lane
	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
	} lane_ctl_t;

endpackage

`default_nettype wire

[rtl/aat_in_if.sv]
// ----------------------------------------------------------------------------
// aat_in_if: input channel of the affine box transform
// Valid/ready channel carrying the 3x3 linear part and the translation.
// ----------------------------------------------------------------------------
`default_nettype none

interface aat_in_if #(
	parameter int W = aat_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [W-1:0] mat_r0c0;
	logic signed [W-1:0] mat_r0c1;
	logic signed [W-1:0] mat_r0c2;
	logic signed [W-1:0] mat_r1c0;
	logic signed [W-1:0] mat_r1c1;
	logic signed [W-1:0] mat_r1c2;
	logic signed [W-1:0] mat_r2c0;
	logic signed [W-1:0] mat_r2c1;
	logic signed [W-1:0] mat_r2c2;
	logic signed [W-1:0] move_x;
	logic signed [W-1:0] move_y;
	logic signed [W-1:0] move_z;

	modport source (
		output valid,
		input  ready,
		output mat_r0c0, mat_r0c1, mat_r0c2,
		output mat_r1c0, mat_r1c1, mat_r1c2,
		output mat_r2c0, mat_r2c1, mat_r2c2,
		output move_x, move_y, move_z
	);

	modport sink (
		input  valid,
		output ready,
		input  mat_r0c0, mat_r0c1, mat_r0c2,
		input  mat_r1c0, mat_r1c1, mat_r1c2,
		input  mat_r2c0, mat_r2c1, mat_r2c2,
		input  move_x, move_y, move_z
	);
endinterface

`default_nettype wire

[rtl/aat_out_if.sv]
// ----------------------------------------------------------------------------
// aat_out_if: output channel of the affine box transform
// Valid/ready channel carrying the enclosing world-space box.
// ----------------------------------------------------------------------------
`default_nettype none

interface aat_out_if #(
	parameter int W = aat_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [W-1:0] world_min_x;
	logic signed [W-1:0] world_min_y;
	logic signed [W-1:0] world_min_z;
	logic signed [W-1:0] world_max_x;
	logic signed [W-1:0] world_max_y;
	logic signed [W-1:0] world_max_z;

	modport source (
		output valid,
		input  ready,
		output world_min_x, world_min_y, world_min_z,
		output world_max_x, world_max_y, world_max_z
	);

	modport sink (
		input  valid,
		output ready,
		input  world_min_x, world_min_y, world_min_z,
		input  world_max_x, world_max_y, world_max_z
	);
endinterface

`default_nettype wire

[rtl/aat_lane.sv]
// ----------------------------------------------------------------------------
// aat_lane: one source-axis lane of the box transform
// Multiplies the column of coefficients for one source axis by the local
// bounds picked by coefficient sign, in two stages: split partial products,
// then recombine and floor-shift out the fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_lane #(
	parameter int CW   = aat_pkg::COORD_WIDTH_DEF,
	parameter int FRAC = aat_pkg::FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire aat_pkg::lane_ctl_t      ctl,
	input  wire logic signed [CW-1:0]    coef [aat_pkg::NUM_AXES],
	input  wire logic signed [CW-1:0]    bnd_min,
	input  wire logic signed [CW-1:0]    bnd_max,
	output logic signed [2*CW-1:0]       term_lo [aat_pkg::NUM_AXES],
	output logic signed [2*CW-1:0]       term_hi [aat_pkg::NUM_AXES]
);

	localparam int LO = CW / 2;
	localparam int HW = CW - LO;
	localparam int PW = 2 * CW;

	logic signed [CW+HW-1:0] ph_lo [aat_pkg::NUM_AXES];
	logic signed [CW+LO:0]   pl_lo [aat_pkg::NUM_AXES];
	logic signed [CW+HW-1:0] ph_hi [aat_pkg::NUM_AXES];
	logic signed [CW+LO:0]   pl_hi [aat_pkg::NUM_AXES];

	logic signed [CW+HW-1:0] ph_lo_s1 [aat_pkg::NUM_AXES];
	logic signed [CW+LO:0]   pl_lo_s1 [aat_pkg::NUM_AXES];
	logic signed [CW+HW-1:0] ph_hi_s1 [aat_pkg::NUM_AXES];
	logic signed [CW+LO:0]   pl_hi_s1 [aat_pkg::NUM_AXES];

	logic signed [PW-1:0] prod_lo [aat_pkg::NUM_AXES];
	logic signed [PW-1:0] prod_hi [aat_pkg::NUM_AXES];

	logic signed [PW-1:0] term_lo_s2 [aat_pkg::NUM_AXES];
	logic signed [PW-1:0] term_hi_s2 [aat_pkg::NUM_AXES];

	// pick bounds by sign and form split partial products
	always_comb begin
		logic          pos;
		logic [CW-1:0] sel_lo;
		logic [CW-1:0] sel_hi;
		for (int r = 0; r < aat_pkg::NUM_AXES; r++) begin
			pos    = (coef[r] != '0) && !coef[r][CW-1];
			sel_lo = pos ? bnd_min : bnd_max;
			sel_hi = pos ? bnd_max : bnd_min;
			ph_lo[r] = coef[r] * signed'(sel_lo[CW-1:LO]);
			pl_lo[r] = coef[r] * signed'({1'b0, sel_lo[LO-1:0]});
			ph_hi[r] = coef[r] * signed'(sel_hi[CW-1:LO]);
			pl_hi[r] = coef[r] * signed'({1'b0, sel_hi[LO-1:0]});
		end
	end

	// hold partial products for the second stage
	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			ph_lo_s1 <= ph_lo;
			pl_lo_s1 <= pl_lo;
			ph_hi_s1 <= ph_hi;
			pl_hi_s1 <= pl_hi;
		end
	end

	// recombine the halves into the exact product
	always_comb begin
		for (int r = 0; r < aat_pkg::NUM_AXES; r++) begin
			prod_lo[r] = (PW'(ph_lo_s1[r]) <<< LO) + PW'(pl_lo_s1[r]);
			prod_hi[r] = (PW'(ph_hi_s1[r]) <<< LO) + PW'(pl_hi_s1[r]);
		end
	end

	// floor-shift out the fraction and register the terms
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			for (int r = 0; r < aat_pkg::NUM_AXES; r++) begin
				term_lo_s2[r] <= prod_lo[r] >>> FRAC;
				term_hi_s2[r] <= prod_hi[r] >>> FRAC;
			end
		end
	end

	assign term_lo = term_lo_s2;
	assign term_hi = term_hi_s2;

endmodule

`default_nettype wire

[rtl/aat_merge.sv]
// ----------------------------------------------------------------------------
// aat_merge: merge stage of the box transform
// Adds the translation and the three lane terms for each output axis,
// saturates to the coordinate range and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_merge #(
	parameter int CW = aat_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  adv,
	input  wire logic signed [CW-1:0]  move [aat_pkg::NUM_AXES],
	input  wire logic signed [2*CW-1:0] term_lo [aat_pkg::NUM_AXES][aat_pkg::NUM_AXES],
	input  wire logic signed [2*CW-1:0] term_hi [aat_pkg::NUM_AXES][aat_pkg::NUM_AXES],
	output logic signed [CW-1:0]       world_min [aat_pkg::NUM_AXES],
	output logic signed [CW-1:0]       world_max [aat_pkg::NUM_AXES]
);

	localparam int SW = 2 * CW + 2;

	logic signed [SW-1:0] sum_lo [aat_pkg::NUM_AXES];
	logic signed [SW-1:0] sum_hi [aat_pkg::NUM_AXES];
	logic signed [CW-1:0] world_min_s3 [aat_pkg::NUM_AXES];
	logic signed [CW-1:0] world_max_s3 [aat_pkg::NUM_AXES];

	// clamp an exact sum to the signed coordinate range
	function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
		logic [SW-CW:0] top;
		logic           fits;
		top  = v[SW-1:CW-1];
		fits = (&top) || !(|top);
		if (fits) begin
			sat = v[CW-1:0];
		end else if (v[SW-1]) begin
			sat = {1'b1, {(CW-1){1'b0}}};
		end else begin
			sat = {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	// sum translation and lane terms, row by row
	always_comb begin
		for (int r = 0; r < aat_pkg::NUM_AXES; r++) begin
			sum_lo[r] = SW'(move[r]) + SW'(term_lo[0][r]) + SW'(term_lo[1][r])
				+ SW'(term_lo[2][r]);
			sum_hi[r] = SW'(move[r]) + SW'(term_hi[0][r]) + SW'(term_hi[1][r])
				+ SW'(term_hi[2][r]);
		end
	end

	// hold the saturated result beat
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < aat_pkg::NUM_AXES; r++) begin
				world_min_s3[r] <= sat(sum_lo[r]);
				world_max_s3[r] <= sat(sum_hi[r]);
			end
		end
	end

	assign world_min = world_min_s3;
	assign world_max = world_max_s3;

endmodule

`default_nettype wire

[rtl/affine_aabb_transform.sv]
// An accepted input beat passes the s1, s2 and s3 registers on its way to rsp.
// Throughput: one item per cycle when not stalled; three lanes (one per source
// axis) each run a two-stage split multiply, then one merge stage sums and
// saturates. A held result beat stalls only the stages behind it; bubbles are
// filled. Reset clears the stage valids and the box registers to zero;
// req.ready stays low after reset is released until run_q is set.
// ----------------------------------------------------------------------------
// affine_aabb_transform: world-space bounding box of a transformed local box
// Applies a 3x3 linear part and a translation to the box held in registers
// and returns the axis-aligned box that encloses the result.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_aabb_transform #(
	parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = aat_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [aat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [COORD_WIDTH-1:0]          cfg_data,
	aat_in_if.sink                               req,
	aat_out_if.source                            rsp
);

	localparam int CW = COORD_WIDTH;
	localparam int NA = aat_pkg::NUM_AXES;

	logic signed [CW-1:0] box_min_q [NA];
	logic signed [CW-1:0] box_max_q [NA];

	logic run_q;
	logic v1_q, v2_q, v3_q;
	logic rdy1, rdy2, rdy3;
	aat_pkg::lane_ctl_t lane_ctl;
	logic adv_s3;

	logic signed [CW-1:0] coef [NA][NA];
	logic signed [CW-1:0] lane_coef [NA][NA];
	logic signed [CW-1:0] move_in [NA];
	logic signed [CW-1:0] move_s1 [NA];
	logic signed [CW-1:0] move_s2 [NA];

	logic signed [2*CW-1:0] term_lo [NA][NA];
	logic signed [2*CW-1:0] term_hi [NA][NA];
	logic signed [CW-1:0]   world_min [NA];
	logic signed [CW-1:0]   world_max [NA];

	// unpack the input beat
	assign coef[0][0] = req.mat_r0c0;
	assign coef[0][1] = req.mat_r0c1;
	assign coef[0][2] = req.mat_r0c2;
	assign coef[1][0] = req.mat_r1c0;
	assign coef[1][1] = req.mat_r1c1;
	assign coef[1][2] = req.mat_r1c2;
	assign coef[2][0] = req.mat_r2c0;
	assign coef[2][1] = req.mat_r2c1;
	assign coef[2][2] = req.mat_r2c2;
	assign move_in[0] = req.move_x;
	assign move_in[1] = req.move_y;
	assign move_in[2] = req.move_z;

	// write box registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NA; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (aat_pkg::cfg_reg_t'(cfg_index))
				aat_pkg::REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				aat_pkg::REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				aat_pkg::REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				aat_pkg::REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				aat_pkg::REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				aat_pkg::REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage readiness: a stage takes a beat when empty or draining
	assign rdy3 = !v3_q || rsp.ready;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign req.ready = rdy1 && run_q;

	assign lane_ctl.adv_s1 = req.valid && req.ready;
	assign lane_ctl.adv_s2 = v1_q && rdy2;
	assign adv_s3          = v2_q && rdy3;

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			v3_q  <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (rdy1) begin
				v1_q <= lane_ctl.adv_s1;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
		end
	end

	// carry the translation alongside the lanes
	always_ff @(posedge clk) begin
		if (lane_ctl.adv_s1) begin
			move_s1 <= move_in;
		end
		if (lane_ctl.adv_s2) begin
			move_s2 <= move_s1;
		end
	end

	// one lane per source axis
	for (genvar j = 0; j < NA; j++) begin : g_lane
		for (genvar r = 0; r < NA; r++) begin : g_col
			assign lane_coef[j][r] = coef[r][j];
		end

		aat_lane #(
			.CW   (CW),
			.FRAC (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.ctl     (lane_ctl),
			.coef    (lane_coef[j]),
			.bnd_min (box_min_q[j]),
			.bnd_max (box_max_q[j]),
			.term_lo (term_lo[j]),
			.term_hi (term_hi[j])
		);
	end

	aat_merge #(
		.CW (CW)
	) u_merge (
		.clk       (clk),
		.adv       (adv_s3),
		.move      (move_s2),
		.term_lo   (term_lo),
		.term_hi   (term_hi),
		.world_min (world_min),
		.world_max (world_max)
	);

	// drive the result beat
	assign rsp.valid       = v3_q;
	assign rsp.world_min_x = world_min[0];
	assign rsp.world_min_y = world_min[1];
	assign rsp.world_min_z = world_min[2];
	assign rsp.world_max_x = world_max[0];
	assign rsp.world_max_y = world_max[1];
	assign rsp.world_max_z = world_max[2];

endmodule

`default_nettype wire

[rtl/aat_chk.sv]
// ----------------------------------------------------------------------------
// aat_chk: port-level checks for the affine box transform
// Watches the handshakes and result beats at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_chk #(
	parameter int CW = aat_pkg::COORD_WIDTH_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire logic [CW-1:0] rsp_min_x,
	input wire logic [CW-1:0] rsp_min_y,
	input wire logic [CW-1:0] rsp_min_z,
	input wire logic [CW-1:0] rsp_max_x,
	input wire logic [CW-1:0] rsp_max_y,
	input wire logic [CW-1:0] rsp_max_z
);

	logic       req_acc;
	logic       rsp_acc;
	logic [2:0] occ_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// track items in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + {2'b00, req_acc} - {2'b00, rsp_acc};
		end
	end

	// no more items in flight than pipeline stages
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'd3)
		else $error("more items in flight than pipeline stages");

	// a fresh result beat follows an accepted input beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_acc, 3))
		else $error("result beat without matching accept");

	// input stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!req_ready && $past(arst_n)) |-> (rsp_valid && !rsp_ready))
		else $error("input stalled without output backpressure");

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_min_x)
			&& $stable(rsp_min_y) && $stable(rsp_min_z) && $stable(rsp_max_x)
			&& $stable(rsp_max_y) && $stable(rsp_max_z)))
		else $error("stalled result beat changed");

endmodule

bind affine_aabb_transform aat_chk #(
	.CW (COORD_WIDTH)
) u_aat_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_min_x (rsp.world_min_x),
	.rsp_min_y (rsp.world_min_y),
	.rsp_min_z (rsp.world_min_z),
	.rsp_max_x (rsp.world_max_x),
	.rsp_max_y (rsp.world_max_y),
	.rsp_max_z (rsp.world_max_z)
);

`default_nettype wire
